// ===== rtl/core/tmi_pkg.sv =====
// Package for the tape machine interpreter core: sizes, command codes,
// status codes, state machine type and the character decoder.
// Depends on nothing; used by every file in rtl/core.
package tmi_pkg;

  localparam int TapeDepth       = 4096;
  localparam int ProgramDepth    = 4096;
  localparam int StackDepthDef   = 64;
  localparam int InQueueDepthDef = 16;

  localparam int TapeAw = $clog2(TapeDepth);
  localparam int ProgAw = $clog2(ProgramDepth);
  localparam int PcW    = 13;
  localparam int LenW   = 13;
  localparam logic [LenW-1:0] TapeLengthReset = LenW'(TapeDepth);

  typedef enum logic [2:0] {
    CMD_INC   = 3'd0,
    CMD_DEC   = 3'd1,
    CMD_RIGHT = 3'd2,
    CMD_LEFT  = 3'd3,
    CMD_OPEN  = 3'd4,
    CMD_CLOSE = 3'd5,
    CMD_OUT   = 3'd6,
    CMD_IN    = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_BYTE  = 3'd1,
    ST_WAIT  = 3'd2,
    ST_HALT  = 3'd3,
    ST_UNBAL = 3'd4,
    ST_FULL  = 3'd5,
    ST_OVF   = 3'd6,
    ST_UNF   = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUEUE = 2'd1,
    OP_STEP  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_STACK,
    S_SKIP,
    S_SKIPC
  } state_e;

  typedef struct packed {
    logic empty;
    logic full;
  } tmi_q_status_t;

  typedef struct packed {
    logic valid;
    cmd_e code;
  } tmi_decode_t;

  function automatic tmi_decode_t decode_char(input logic [7:0] ch);
    tmi_decode_t d;
    d.valid = 1'b1;
    d.code  = CMD_INC;
    case (ch)
      8'h2B:   d.code = CMD_INC;
      8'h2D:   d.code = CMD_DEC;
      8'h3E:   d.code = CMD_RIGHT;
      8'h3C:   d.code = CMD_LEFT;
      8'h5B:   d.code = CMD_OPEN;
      8'h5D:   d.code = CMD_CLOSE;
      8'h2E:   d.code = CMD_OUT;
      8'h2C:   d.code = CMD_IN;
      default: d.valid = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/tape_machine_interpreter_core.sv =====
// Top level of the tape machine interpreter core: sequencer, tape memory,
// program store and loop return stack. Depends on tmi_pkg and tmi_in_queue.
//
// Each word taken on start/busy yields exactly one result, shown for one cycle
// while result_valid_o is high; the receiver cannot stall, so take it then.
// Load, queue and no-op words answer in the cycle after acceptance, as does a
// step word refused because the program is unbalanced or halted. A step
// word runs S_EXEC and answers from there for +, -, ., ',' and a taken
// '[' or plain ']'; pointer moves go on to S_LOAD (tape reread at the new
// pointer) and backward jumps to S_STACK (return stack read), and a forward
// skip over N program characters alternates S_SKIP and S_SKIPC, walking the
// program store one entry per pair of states. After reset busy stays high
// while the tape is swept to zero; tape length writes are taken at any time.
module tape_machine_interpreter_core #(
  parameter int StackDepth   = tmi_pkg::StackDepthDef,
  parameter int InQueueDepth = tmi_pkg::InQueueDepthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               operation_i,
  input  logic [7:0]               data_byte_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [tmi_pkg::LenW-1:0] cfg_data_i,
  output logic                     result_valid_o,
  output logic [2:0]               status_o,
  output logic [7:0]               out_byte_o,
  output logic [11:0]              cell_index_o,
  output logic [7:0]               cell_value_o,
  output logic [12:0]              program_counter_o
);
  import tmi_pkg::*;

  localparam int SpW = $clog2(StackDepth + 1);
  localparam int SaW = $clog2(StackDepth);

  // memories
  logic [7:0]        tape_mem  [TapeDepth];
  logic [2:0]        prog_mem  [ProgramDepth];
  logic [ProgAw-1:0] stack_mem [StackDepth];

  state_e state_q, state_d;

  logic [LenW-1:0]   tlen_q, plen_q, plen_d, bal_q, bal_d, sdepth_q, sdepth_d;
  logic [PcW-1:0]    pc_q, pc_d, skip_q, skip_d;
  logic [TapeAw-1:0] ptr_q, ptr_d, clr_q;
  logic [7:0]        cell_q, cell_d, obyte_q, obyte_d;
  logic [SpW-1:0]    sp_q, sp_d;
  logic              unbal_q, unbal_d, done_q, done_d;
  status_e           stat_q, stat_d;

  logic              accept, unbal, pc_end, cell_zero, stk_full, stk_empty, skip_end;
  logic              clr_last;
  logic [LenW-1:0]   len;
  logic [LenW-1:0]   ptr_ext;
  tmi_decode_t       dec;
  cmd_e              cmd;
  logic [2:0]        prog_rdata;
  logic [ProgAw-1:0] prog_raddr;
  logic [7:0]        tape_rdata;
  logic              tape_we;
  logic [TapeAw-1:0] tape_waddr;
  logic [7:0]        tape_wdata;
  logic [ProgAw-1:0] stk_rdata;
  logic              stk_we, q_push, q_pop;
  logic [7:0]        q_head;
  tmi_q_status_t     q_stat;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign unbal       = unbal_q || (bal_q != '0);
  assign pc_end      = (pc_q >= plen_q);
  assign cell_zero   = (cell_q == 8'd0);
  assign stk_full    = (sp_q >= SpW'(StackDepth));
  assign stk_empty   = (sp_q == '0);
  assign skip_end    = (skip_q >= plen_q);
  assign clr_last    = (clr_q == TapeAw'(TapeDepth - 1));
  assign dec         = decode_char(data_byte_i);
  assign cmd         = cmd_e'(prog_rdata);
  assign ptr_ext     = {{(LenW-TapeAw){1'b0}}, ptr_q};

  // clamp the configured length into 1 .. tape depth
  always_comb begin
    if (tlen_q == '0) begin
      len = LenW'(1);
    end else if (tlen_q > LenW'(TapeDepth)) begin
      len = LenW'(TapeDepth);
    end else begin
      len = tlen_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_last) state_d = S_IDLE;
      S_IDLE: begin
        if (accept && op_e'(operation_i) == OP_STEP && !unbal && !pc_end) state_d = S_EXEC;
      end
      S_EXEC: begin
        case (cmd) inside
          CMD_RIGHT, CMD_LEFT: state_d = S_LOAD;
          CMD_OPEN:  state_d = cell_zero ? S_SKIP : S_IDLE;
          CMD_CLOSE: state_d = (!stk_empty && !cell_zero) ? S_STACK : S_IDLE;
          default:   state_d = S_IDLE;
        endcase
      end
      S_SKIP:  state_d = skip_end ? S_IDLE : S_SKIPC;
      S_SKIPC: begin
        state_d = (cmd == CMD_CLOSE && sdepth_q == '0) ? S_IDLE : S_SKIP;
      end
      S_LOAD, S_STACK: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    plen_d     = plen_q;
    bal_d      = bal_q;
    unbal_d    = unbal_q;
    pc_d       = pc_q;
    ptr_d      = ptr_q;
    cell_d     = cell_q;
    sp_d       = sp_q;
    skip_d     = skip_q;
    sdepth_d   = sdepth_q;
    done_d     = 1'b0;
    stat_d     = stat_q;
    obyte_d    = obyte_q;
    tape_we    = 1'b0;
    tape_waddr = ptr_q;
    tape_wdata = cell_q;
    stk_we     = 1'b0;
    q_push     = 1'b0;
    q_pop      = 1'b0;
    prog_raddr = pc_q[ProgAw-1:0];

    unique case (state_q)
      S_CLEAR: begin
        tape_we    = 1'b1;
        tape_waddr = clr_q;
        tape_wdata = 8'd0;
      end
      S_IDLE: begin
        if (accept) begin
          done_d  = 1'b1;
          stat_d  = ST_OK;
          obyte_d = 8'd0;
          case (op_e'(operation_i))
            OP_LOAD: begin
              if (dec.valid) begin
                if (plen_q >= LenW'(ProgramDepth)) begin
                  stat_d = ST_FULL;
                end else begin
                  plen_d = plen_q + LenW'(1);
                  if (dec.code == CMD_OPEN) begin
                    bal_d = bal_q + LenW'(1);
                  end else if (dec.code == CMD_CLOSE) begin
                    if (bal_q == '0) unbal_d = 1'b1;
                    else bal_d = bal_q - LenW'(1);
                  end
                end
              end
            end
            OP_QUEUE: begin
              if (q_stat.full) stat_d = ST_FULL;
              else q_push = 1'b1;
            end
            OP_STEP: begin
              if (unbal) begin
                stat_d = ST_UNBAL;
              end else if (pc_end) begin
                stat_d = ST_HALT;
              end else begin
                done_d = 1'b0;   // hold result until the instruction resolves
              end
            end
            default: ;
          endcase
        end
      end
      S_EXEC: begin
        done_d = 1'b1;
        stat_d = ST_OK;
        case (cmd)
          CMD_INC: begin
            cell_d  = cell_q + 8'd1;
            tape_we = 1'b1; tape_wdata = cell_d;
            pc_d    = pc_q + PcW'(1);
          end
          CMD_DEC: begin
            cell_d  = cell_q - 8'd1;
            tape_we = 1'b1; tape_wdata = cell_d;
            pc_d    = pc_q + PcW'(1);
          end
          CMD_RIGHT: begin
            done_d = 1'b0;
            ptr_d  = (ptr_ext + LenW'(1) >= len) ? '0 : ptr_q + TapeAw'(1);
            pc_d   = pc_q + PcW'(1);
          end
          CMD_LEFT: begin
            done_d = 1'b0;
            ptr_d  = (ptr_q == '0 || ptr_ext >= len) ? TapeAw'(len - LenW'(1))
                                                     : ptr_q - TapeAw'(1);
            pc_d   = pc_q + PcW'(1);
          end
          CMD_OPEN: begin
            if (cell_zero) begin
              done_d   = 1'b0;
              skip_d   = pc_q + PcW'(1);
              sdepth_d = '0;
            end else if (stk_full) begin
              stat_d = ST_OVF;
            end else begin
              stk_we = 1'b1;
              sp_d   = sp_q + SpW'(1);
              pc_d   = pc_q + PcW'(1);
            end
          end
          CMD_CLOSE: begin
            if (stk_empty) begin
              stat_d = ST_UNF;
            end else if (cell_zero) begin
              sp_d = sp_q - SpW'(1);
              pc_d = pc_q + PcW'(1);
            end else begin
              done_d = 1'b0;
            end
          end
          CMD_OUT: begin
            stat_d  = ST_BYTE;
            obyte_d = cell_q;
            pc_d    = pc_q + PcW'(1);
          end
          default: begin
            if (q_stat.empty) begin
              stat_d = ST_WAIT;
            end else begin
              q_pop   = 1'b1;
              cell_d  = q_head;
              tape_we = 1'b1; tape_wdata = q_head;
              pc_d    = pc_q + PcW'(1);
            end
          end
        endcase
      end
      S_LOAD: begin
        cell_d = tape_rdata;
        done_d = 1'b1;
      end
      S_STACK: begin
        pc_d   = {{(PcW-ProgAw){1'b0}}, stk_rdata} + PcW'(1);
        done_d = 1'b1;
      end
      S_SKIP: begin
        prog_raddr = skip_q[ProgAw-1:0];
        if (skip_end) begin
          done_d = 1'b1;
          stat_d = ST_UNBAL;
        end
      end
      S_SKIPC: begin
        skip_d = skip_q + PcW'(1);
        if (cmd == CMD_OPEN) begin
          sdepth_d = sdepth_q + LenW'(1);
        end else if (cmd == CMD_CLOSE) begin
          if (sdepth_q == '0) begin
            pc_d   = skip_q + PcW'(1);
            done_d = 1'b1;
          end else begin
            sdepth_d = sdepth_q - LenW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      tlen_q   <= TapeLengthReset;
      plen_q   <= '0;
      bal_q    <= '0;
      unbal_q  <= 1'b0;
      pc_q     <= '0;
      ptr_q    <= '0;
      cell_q   <= 8'd0;
      sp_q     <= '0;
      skip_q   <= '0;
      sdepth_q <= '0;
      done_q   <= 1'b0;
      stat_q   <= ST_OK;
      obyte_q  <= 8'd0;
    end else begin
      state_q  <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + TapeAw'(1);
      if (cfg_valid_i) tlen_q <= cfg_data_i;
      plen_q   <= plen_d;
      bal_q    <= bal_d;
      unbal_q  <= unbal_d;
      pc_q     <= pc_d;
      ptr_q    <= ptr_d;
      cell_q   <= cell_d;
      sp_q     <= sp_d;
      skip_q   <= skip_d;
      sdepth_q <= sdepth_d;
      done_q   <= done_d;
      stat_q   <= stat_d;
      obyte_q  <= obyte_d;
    end
  end

  // tape: one write port, one registered read at the next pointer
  always_ff @(posedge clk_i) begin
    if (tape_we) tape_mem[tape_waddr] <= tape_wdata;
    tape_rdata <= tape_mem[ptr_d];
  end

  // program store: written on load, read at the pc or the skip cursor
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && accept && op_e'(operation_i) == OP_LOAD && dec.valid
        && plen_q < LenW'(ProgramDepth)) begin
      prog_mem[plen_q[ProgAw-1:0]] <= dec.code;
    end
    prog_rdata <= prog_mem[prog_raddr];
  end

  // loop return stack: push the pc, read the top ahead of a backward jump
  always_ff @(posedge clk_i) begin
    if (stk_we) stack_mem[sp_q[SaW-1:0]] <= pc_q[ProgAw-1:0];
    stk_rdata <= stack_mem[SaW'(sp_q - SpW'(1))];
  end

  tmi_in_queue #(
    .Depth(InQueueDepth)
  ) u_in_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(data_byte_i),
    .pop_i      (q_pop),
    .head_data_o(q_head),
    .status_o   (q_stat)
  );

  assign result_valid_o    = done_q;
  assign status_o          = stat_q;
  assign out_byte_o        = obyte_q;
  assign cell_index_o      = ptr_q;
  assign cell_value_o      = cell_q;
  assign program_counter_o = pc_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) sp_q <= SpW'(StackDepth))
    else $error("return stack pointer beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni) plen_q <= LenW'(ProgramDepth))
    else $error("program length beyond store depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD || state_q == S_STACK) |=> (done_q && state_q == S_IDLE))
    else $error("result missing after tape reread or stack read");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) != S_CLEAR)
    else $error("result strobe during tape clear");

endmodule

// ===== rtl/core/tmi_in_queue.sv =====
// Input byte queue of the tape machine interpreter core.
// Depends on tmi_pkg for the status struct.
module tmi_in_queue #(
  parameter int Depth = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [7:0]             push_data_i,
  input  logic                   pop_i,
  output logic [7:0]             head_data_o,
  output tmi_pkg::tmi_q_status_t status_o
);
  import tmi_pkg::*;

  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int Cw = $clog2(Depth + 1);

  logic [7:0]    mem_q [Depth];
  logic [Aw-1:0] head_q, head_d, tail_q, tail_d;
  logic [Cw-1:0] count_q, count_d;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (push_i) begin
      tail_d  = (tail_q == Aw'(Depth - 1)) ? '0 : tail_q + Aw'(1);
      count_d = count_q + Cw'(1);
    end else if (pop_i) begin
      head_d  = (head_q == Aw'(Depth - 1)) ? '0 : head_q + Aw'(1);
      count_d = count_q - Cw'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= push_data_i;
    end
  end

  assign head_data_o    = mem_q[head_q];
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q >= Cw'(Depth));

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= Cw'(Depth))
    else $error("input queue count beyond depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !status_o.full) |=> !status_o.empty)
    else $error("queue empty after a push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("pop from empty input queue");

endmodule
